// ===== rtl/core/micp_pkg.sv =====
// ---------------------------------------------------------------------------
// micp_pkg
// Shared types and constants for the impedance command packer.
// ---------------------------------------------------------------------------
`default_nettype none

package micp_pkg;

    localparam int LimitW   = 31;
    localparam int IdW      = 8;
    localparam int ValW     = 32;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 31;
    localparam int StatusW  = 2;
    localparam int PayloadW = 64;
    // offset and span are at most 2^32 - 2, so 33 bits cover them
    localparam int SpanW    = 33;
    // offset * (2^16 - 1) fits in 49 bits
    localparam int NumW     = 49;
    localparam int QuoW     = 16;
    localparam int CntW     = 6;
    localparam int FieldCnt = 5;
    localparam int FieldIdxW = 3;

    typedef enum logic [CfgAddrW-1:0] {
        REG_POS_LIMIT  = 3'd0,
        REG_VEL_LIMIT  = 3'd1,
        REG_TRQ_LIMIT  = 3'd2,
        REG_KP_LIMIT   = 3'd3,
        REG_KD_LIMIT   = 3'd4,
        REG_ID_LOW     = 3'd5,
        REG_ID_HIGH    = 3'd6
    } t_reg_idx;

    typedef enum logic [StatusW-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ID  = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    // one classified command handed from the front to the back
    typedef struct packed {
        t_status              status;
        logic [IdW-1:0]       id;
        logic [SpanW-1:0]     off_p;
        logic [SpanW-1:0]     span_p;
        logic [SpanW-1:0]     off_v;
        logic [SpanW-1:0]     span_v;
        logic [SpanW-1:0]     off_kp;
        logic [SpanW-1:0]     span_kp;
        logic [SpanW-1:0]     off_kd;
        logic [SpanW-1:0]     span_kd;
        logic [SpanW-1:0]     off_t;
        logic [SpanW-1:0]     span_t;
    } t_cmd;

    typedef struct packed {
        logic [LimitW-1:0] pos_lim;
        logic [LimitW-1:0] vel_lim;
        logic [LimitW-1:0] trq_lim;
        logic [LimitW-1:0] kp_lim;
        logic [LimitW-1:0] kd_lim;
        logic [IdW-1:0]    id_low;
        logic [IdW-1:0]    id_high;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/micp_front.sv =====
// ---------------------------------------------------------------------------
// micp_front
// Range checks and offset/span forming for one command word per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module micp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire micp_pkg::t_cfg                i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [micp_pkg::IdW-1:0]      i_motor_id,
    input  wire logic signed [micp_pkg::ValW-1:0] i_pos,
    input  wire logic signed [micp_pkg::ValW-1:0] i_vel,
    input  wire logic signed [micp_pkg::ValW-1:0] i_kp,
    input  wire logic signed [micp_pkg::ValW-1:0] i_kd,
    input  wire logic signed [micp_pkg::ValW-1:0] i_trq,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output micp_pkg::t_cmd                     o_cmd
);

    localparam int SW = micp_pkg::SpanW;

    logic           r_valid;
    micp_pkg::t_cmd r_cmd;
    micp_pkg::t_cmd n_cmd;

    // signed 34-bit views
    logic signed [SW:0] pos_s, vel_s, kp_s, kd_s, trq_s;
    logic signed [SW:0] pl_s, vl_s, tl_s, gp_s, gd_s;
    logic               id_ok, lim_ok, val_ok;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        pos_s = (SW+1)'(i_pos);
        vel_s = (SW+1)'(i_vel);
        kp_s  = (SW+1)'(i_kp);
        kd_s  = (SW+1)'(i_kd);
        trq_s = (SW+1)'(i_trq);
        pl_s  = $signed({3'b000, i_cfg.pos_lim});
        vl_s  = $signed({3'b000, i_cfg.vel_lim});
        tl_s  = $signed({3'b000, i_cfg.trq_lim});
        gp_s  = $signed({3'b000, i_cfg.kp_lim});
        gd_s  = $signed({3'b000, i_cfg.kd_lim});

        id_ok  = (i_motor_id >= i_cfg.id_low) && (i_motor_id <= i_cfg.id_high);
        lim_ok = (i_cfg.pos_lim != '0) && (i_cfg.vel_lim != '0) &&
                 (i_cfg.trq_lim != '0) && (i_cfg.kp_lim != '0) &&
                 (i_cfg.kd_lim != '0);
        val_ok = (pos_s >= -pl_s) && (pos_s <= pl_s) &&
                 (vel_s >= -vl_s) && (vel_s <= vl_s) &&
                 (trq_s >= -tl_s) && (trq_s <= tl_s) &&
                 (kp_s >= 0) && (kp_s <= gp_s) &&
                 (kd_s >= 0) && (kd_s <= gd_s);

        n_cmd         = '0;
        n_cmd.id      = i_motor_id;
        n_cmd.off_p   = SW'(pos_s + pl_s);
        n_cmd.span_p  = SW'(pl_s + pl_s);
        n_cmd.off_v   = SW'(vel_s + vl_s);
        n_cmd.span_v  = SW'(vl_s + vl_s);
        n_cmd.off_t   = SW'(trq_s + tl_s);
        n_cmd.span_t  = SW'(tl_s + tl_s);
        n_cmd.off_kp  = SW'(kp_s);
        n_cmd.span_kp = SW'(gp_s);
        n_cmd.off_kd  = SW'(kd_s);
        n_cmd.span_kd = SW'(gd_s);
        if (!id_ok) begin
            n_cmd.status = micp_pkg::ST_BAD_ID;
        end else if (!(lim_ok && val_ok)) begin
            n_cmd.status = micp_pkg::ST_RANGE;
        end else begin
            n_cmd.status = micp_pkg::ST_OK;
        end
    end

    // output stage of the front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/micp_fifo.sv =====
// ---------------------------------------------------------------------------
// micp_fifo
// Two-entry queue of classified command words between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module micp_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire micp_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_ready,
    output micp_pkg::t_cmd      o_cmd
);

    micp_pkg::t_cmd r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/micp_back.sv =====
// ---------------------------------------------------------------------------
// micp_back
// Scales the five fields with one shared restoring divider and packs the
// payload word.
// ---------------------------------------------------------------------------
`default_nettype none

module micp_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire micp_pkg::t_cmd                   i_cmd,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [micp_pkg::StatusW-1:0]          o_status,
    output logic [micp_pkg::IdW-1:0]              o_frame_identifier,
    output logic [micp_pkg::PayloadW-1:0]         o_frame_payload
);

    localparam int SW = micp_pkg::SpanW;
    localparam int NW = micp_pkg::NumW;
    localparam int QW = micp_pkg::QuoW;
    localparam int CW = micp_pkg::CntW;
    localparam int FW = micp_pkg::FieldIdxW;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_DONE} t_state;

    t_state                     r_state;
    micp_pkg::t_cmd             r_cmd;
    logic [FW-1:0]              r_fld;
    logic [CW-1:0]              r_cnt;
    logic [NW-1:0]              r_num;
    logic [SW:0]                r_rem;
    logic [QW-1:0]              r_quo;
    logic [micp_pkg::PayloadW-1:0] r_pay;
    logic                       r_ovalid;
    logic [micp_pkg::StatusW-1:0] r_ost;
    logic [micp_pkg::IdW-1:0]   r_oid;
    logic [micp_pkg::PayloadW-1:0] r_opay;

    logic [SW-1:0]  sel_off, sel_span;
    logic [4:0]     sel_bits;
    logic [SW:0]    trial;
    logic [SW:0]    rem_sh;
    logic [NW-1:0]  prod;
    logic           take;

    assign o_ready = (r_state == S_IDLE);
    assign take    = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_status = r_ost;
    assign o_frame_identifier = r_oid;
    assign o_frame_payload = r_opay;

    // field select
    always_comb begin
        case (r_fld)
            3'd0: begin
                sel_off = r_cmd.off_p;  sel_span = r_cmd.span_p;  sel_bits = 5'd16;
            end
            3'd1: begin
                sel_off = r_cmd.off_v;  sel_span = r_cmd.span_v;  sel_bits = 5'd12;
            end
            3'd2: begin
                sel_off = r_cmd.off_kp; sel_span = r_cmd.span_kp; sel_bits = 5'd12;
            end
            3'd3: begin
                sel_off = r_cmd.off_kd; sel_span = r_cmd.span_kd; sel_bits = 5'd12;
            end
            default: begin
                sel_off = r_cmd.off_t;  sel_span = r_cmd.span_t;  sel_bits = 5'd12;
            end
        endcase
        // offset * (2^bits - 1) = (offset << bits) - offset
        prod   = (NW'(sel_off) << sel_bits) - NW'(sel_off);
        rem_sh = {r_rem[SW-1:0], r_num[NW-1]};
        trial  = rem_sh - {1'b0, sel_span};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // the done state reloads the output word itself
            if (r_ovalid && i_ready && (r_state != S_DONE)) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_cmd <= i_cmd;
                        r_fld <= '0;
                        r_pay <= '0;
                        r_state <= (i_cmd.status == micp_pkg::ST_OK) ? S_LOAD : S_DONE;
                    end
                end
                S_LOAD: begin
                    r_num <= prod;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= CW'(NW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit a cycle
                    r_num <= {r_num[NW-2:0], 1'b0};
                    if (!trial[SW]) begin
                        r_rem <= trial;
                        r_quo <= {r_quo[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[QW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        if (r_fld == 3'd0) begin
                            r_pay <= {(!trial[SW] ? {r_quo[QW-2:0], 1'b1}
                                                  : {r_quo[QW-2:0], 1'b0}), 48'd0};
                        end else begin
                            r_pay <= {r_pay[63:48], r_pay[35:0],
                                      (!trial[SW] ? {r_quo[10:0], 1'b1}
                                                  : {r_quo[10:0], 1'b0})};
                        end
                        if (r_fld == FW'(micp_pkg::FieldCnt - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_fld <= r_fld + 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_ost    <= r_cmd.status;
                        if (r_cmd.status == micp_pkg::ST_OK) begin
                            r_oid  <= r_cmd.id;
                            r_opay <= r_pay;
                        end else begin
                            r_oid  <= '0;
                            r_opay <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/motor_impedance_command_packer.sv =====
// ---------------------------------------------------------------------------
// motor_impedance_command_packer
// Checks an impedance command and packs it into a CAN identifier and payload.
// ---------------------------------------------------------------------------
// Path: a word is registered in the front, queued, and taken by the back; a
// rejected word goes straight to done, a packed one first runs five fields,
// each a load state plus 49 divider steps. The back takes a new word only
// once idle again; the front keeps accepting into a two-entry queue.
// Reset: synchronous, active low; limit registers return to their defaults.
`default_nettype none

module motor_impedance_command_packer (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [micp_pkg::CfgAddrW-1:0]        i_cfg_idx,
    input  wire logic [micp_pkg::CfgDataW-1:0]        i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [micp_pkg::IdW-1:0]             i_motor_id,
    input  wire logic signed [micp_pkg::ValW-1:0]     i_target_position,
    input  wire logic signed [micp_pkg::ValW-1:0]     i_target_velocity,
    input  wire logic signed [micp_pkg::ValW-1:0]     i_stiffness_gain,
    input  wire logic signed [micp_pkg::ValW-1:0]     i_damping_gain,
    input  wire logic signed [micp_pkg::ValW-1:0]     i_feed_torque,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [micp_pkg::StatusW-1:0]              o_status,
    output logic [micp_pkg::IdW-1:0]                  o_frame_identifier,
    output logic [micp_pkg::PayloadW-1:0]             o_frame_payload
);

    micp_pkg::t_cfg r_cfg;
    micp_pkg::t_cmd f_cmd, q_cmd;
    logic           f_valid, f_ready, q_valid, q_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_lim <= micp_pkg::LimitW'(819200);
            r_cfg.vel_lim <= micp_pkg::LimitW'(2949120);
            r_cfg.trq_lim <= micp_pkg::LimitW'(1179648);
            r_cfg.kp_lim  <= micp_pkg::LimitW'(32768000);
            r_cfg.kd_lim  <= micp_pkg::LimitW'(327680);
            r_cfg.id_low  <= micp_pkg::IdW'(1);
            r_cfg.id_high <= micp_pkg::IdW'(15);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                micp_pkg::REG_POS_LIMIT: r_cfg.pos_lim <= i_cfg_data;
                micp_pkg::REG_VEL_LIMIT: r_cfg.vel_lim <= i_cfg_data;
                micp_pkg::REG_TRQ_LIMIT: r_cfg.trq_lim <= i_cfg_data;
                micp_pkg::REG_KP_LIMIT:  r_cfg.kp_lim  <= i_cfg_data;
                micp_pkg::REG_KD_LIMIT:  r_cfg.kd_lim  <= i_cfg_data;
                micp_pkg::REG_ID_LOW:    r_cfg.id_low  <= i_cfg_data[micp_pkg::IdW-1:0];
                micp_pkg::REG_ID_HIGH:   r_cfg.id_high <= i_cfg_data[micp_pkg::IdW-1:0];
                default: ;
            endcase
        end
    end

    micp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_motor_id(i_motor_id), .i_pos(i_target_position),
        .i_vel(i_target_velocity), .i_kp(i_stiffness_gain),
        .i_kd(i_damping_gain), .i_trq(i_feed_torque),
        .o_valid(f_valid), .i_ready(f_ready), .o_cmd(f_cmd)
    );

    micp_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_cmd(f_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    micp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_frame_identifier(o_frame_identifier),
        .o_frame_payload(o_frame_payload)
    );

endmodule

`default_nettype wire
